FILE: sv/json_escape_to_utf8_macros.svh
// assertion macros shared by the json unescape block
`ifndef JSON_ESCAPE_TO_UTF8_MACROS_SVH
`define JSON_ESCAPE_TO_UTF8_MACROS_SVH
`ifndef SYNTHESIS
`define JEU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("jeu assertion failed");
`define JEU_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("jeu assertion failed");
`else
`define JEU_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define JEU_ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`endif
`endif

FILE: sv/jeu_pkg.sv
// shared types and constants of the json unescape block
package jeu_pkg;

	localparam int QueueDepth = 4;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_RAW  = 2'd1;
	localparam logic [1:0] KIND_CP   = 2'd2;

	typedef struct packed {
		logic        last;
		logic        hi_en;
		logic [9:0]  hi;
		logic [1:0]  kind;
		logic [20:0] val;
	} jeu_entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} jeu_qstat_t;

endpackage

FILE: sv/json_escape_to_utf8.sv
// top level of the json string unescaper with utf-8 output
//
// channel  dir  tdata                 tlast
// s_axis   in   [7:0] char_in         is_end
// m_axis   out  [7:0] byte_out        run_last
//
// one character is taken per cycle while the queue has room and no string end is being closed
// a \u escape gives 1 to 4 bytes, a held high surrogate 3 more, at one byte per cycle unless m_axis stalls
// a string end holds s_axis_tready low until the end entry is queued; a trailing backslash is dropped first
// an open \u first queues a 'u', then its held characters are replayed and parsed again
// the entry queue lets input and output stall apart; arst_n clears all control state
module json_escape_to_utf8 #(
	parameter int QUEUE_DEPTH = jeu_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_in
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] byte_out
	output logic       m_axis_tlast
);
	import jeu_pkg::*;

	logic       push;
	logic       pop;
	jeu_entry_t push_entry;
	jeu_entry_t head;
	jeu_qstat_t q_stat;

	jeu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_char    (s_axis_tdata),
		.in_end     (s_axis_tlast),
		.push       (push),
		.push_entry (push_entry),
		.q_stat     (q_stat)
	);

	jeu_fifo #(
		.Depth (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	jeu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

FILE: sv/jeu_front.sv
// front end: escape parsing, surrogate pairing and end-of-string replay
module jeu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_char,
	input  logic               in_end,
	output logic               push,
	output jeu_pkg::jeu_entry_t push_entry,
	input  jeu_pkg::jeu_qstat_t q_stat
);
	import jeu_pkg::*;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_ESC    = 2'd1;
	localparam logic [1:0] MODE_HEX    = 2'd2;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FIN    = 2'd1;
	localparam logic [1:0] PH_REPLAY = 2'd2;

	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [7:0] BYTE_CR  = 8'h0D;

	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
	localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	typedef struct packed {
		logic       ok;
		logic [3:0] d;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok = 1'b1;
		r.d  = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.d = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.d = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.d = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	logic [1:0]  mode_q, mode_d, f_mode;
	logic [15:0] hv_q, hv_d, f_hv;
	logic [1:0]  hc_q, hc_d, f_hc;
	logic        hs_q, hs_d, f_hs;
	logic [7:0]  held_q [3];
	logic [7:0]  held_d [3];
	logic [7:0]  f_held [3];
	logic [9:0]  ph_q, ph_d, f_ph;
	logic        pv_q, pv_d, f_pv;
	logic        f_hi;
	logic [1:0]  f_kind;
	logic [20:0] f_val;
	logic [1:0]  phase_q, phase_d;
	logic [7:0]  rep_q [3];
	logic [7:0]  rep_d [3];
	logic [1:0]  rep_n_q, rep_n_d;
	logic [1:0]  rep_k_q, rep_k_d;
	logic [7:0]  feed_c;
	logic        step;
	hex_t        hx;
	jeu_entry_t  e;

	assign feed_c   = (phase_q == PH_REPLAY) ? rep_q[rep_k_q] : in_char;
	assign hx       = hex_decode(feed_c);
	assign in_ready = (phase_q == PH_IDLE) && !q_stat.full;
	assign step     = !q_stat.full && ((phase_q != PH_IDLE) || in_valid);

	// one character through the escape parser
	always_comb begin
		logic [15:0] v;
		logic        is_lo;
		logic        is_hi;
		f_mode = mode_q;
		f_hv   = hv_q;
		f_hc   = hc_q;
		f_hs   = hs_q;
		f_held = held_q;
		f_ph   = ph_q;
		f_pv   = pv_q;
		f_hi   = 1'b0;
		f_kind = KIND_NONE;
		f_val  = '0;
		v      = '0;
		is_lo  = 1'b0;
		is_hi  = 1'b0;
		if (mode_q == MODE_ESC) begin
			f_mode = MODE_NORMAL;
			if (feed_c == CH_U) begin
				f_mode = MODE_HEX;
				f_hv   = '0;
				f_hc   = '0;
				f_hs   = 1'b0;
			end else begin
				f_hi   = pv_q;
				f_pv   = 1'b0;
				f_kind = KIND_RAW;
				if (feed_c == CH_N) begin
					f_val = {13'd0, BYTE_LF};
				end else if (feed_c == CH_T) begin
					f_val = {13'd0, BYTE_TAB};
				end else if (feed_c == CH_R) begin
					f_val = {13'd0, BYTE_CR};
				end else begin
					f_val = {13'd0, feed_c};
				end
			end
		end else if (mode_q == MODE_HEX) begin
			if (hc_q != 2'd3) begin
				f_held[hc_q] = feed_c;
			end
			if (!hs_q && hx.ok) begin
				f_hv = {hv_q[11:0], hx.d};
			end else begin
				f_hs = 1'b1;
			end
			if (hc_q == 2'd3) begin
				f_mode = MODE_NORMAL;
				f_hc   = '0;
				v      = f_hv;
				is_lo  = (v >= SURR_LO_MIN) && (v <= SURR_LO_MAX);
				is_hi  = (v >= SURR_HI_MIN) && (v <= SURR_HI_MAX);
				if (pv_q && is_lo) begin
					f_kind = KIND_CP;
					f_val  = SUPP_BASE + {1'b0, ph_q, v[9:0]};
					f_pv   = 1'b0;
				end else begin
					f_hi = pv_q;
					f_pv = 1'b0;
					if (is_hi) begin
						f_ph = v[9:0];
						f_pv = 1'b1;
					end else begin
						f_kind = KIND_CP;
						f_val  = {5'd0, v};
					end
				end
			end else begin
				f_hc = hc_q + 2'd1;
			end
		end else begin
			if (feed_c == CH_BSL) begin
				f_mode = MODE_ESC;
			end else begin
				f_hi   = pv_q;
				f_pv   = 1'b0;
				f_kind = KIND_RAW;
				f_val  = {13'd0, feed_c};
			end
		end
	end

	// sequencer: input character, replay of held characters, end-of-string check
	always_comb begin
		mode_d  = mode_q;
		hv_d    = hv_q;
		hc_d    = hc_q;
		hs_d    = hs_q;
		held_d  = held_q;
		ph_d    = ph_q;
		pv_d    = pv_q;
		phase_d = phase_q;
		rep_d   = rep_q;
		rep_n_d = rep_n_q;
		rep_k_d = rep_k_q;
		e       = '0;
		e.hi    = ph_q;
		unique case (phase_q)
			PH_IDLE, PH_REPLAY: begin
				mode_d  = f_mode;
				hv_d    = f_hv;
				hc_d    = f_hc;
				hs_d    = f_hs;
				held_d  = f_held;
				ph_d    = f_ph;
				pv_d    = f_pv;
				e.hi_en = f_hi;
				e.kind  = f_kind;
				e.val   = f_val;
				if (phase_q == PH_IDLE) begin
					e.last = !in_end;
					if (in_end) begin
						phase_d = PH_FIN;
					end
				end else begin
					rep_k_d = rep_k_q + 2'd1;
					if (rep_k_q == rep_n_q - 2'd1) begin
						phase_d = PH_FIN;
					end
				end
			end
			PH_FIN: begin
				if (mode_q == MODE_ESC) begin
					mode_d = MODE_NORMAL;
				end else if (mode_q == MODE_HEX) begin
					e.hi_en = pv_q;
					e.kind  = KIND_RAW;
					e.val   = {13'd0, CH_U};
					pv_d    = 1'b0;
					mode_d  = MODE_NORMAL;
					hc_d    = '0;
					rep_d   = held_q;
					rep_n_d = hc_q;
					rep_k_d = '0;
					if (hc_q != 2'd0) begin
						phase_d = PH_REPLAY;
					end
				end else begin
					e.hi_en = pv_q;
					e.last  = 1'b1;
					mode_d  = MODE_NORMAL;
					hv_d    = '0;
					hc_d    = '0;
					hs_d    = 1'b0;
					ph_d    = '0;
					pv_d    = 1'b0;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	assign push       = step && (e.hi_en || (e.kind != KIND_NONE) || e.last);
	assign push_entry = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			hv_q    <= '0;
			hc_q    <= '0;
			hs_q    <= 1'b0;
			ph_q    <= '0;
			pv_q    <= 1'b0;
			phase_q <= PH_IDLE;
			rep_n_q <= '0;
			rep_k_q <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			hv_q    <= hv_d;
			hc_q    <= hc_d;
			hs_q    <= hs_d;
			ph_q    <= ph_d;
			pv_q    <= pv_d;
			phase_q <= phase_d;
			rep_n_q <= rep_n_d;
			rep_k_q <= rep_k_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			held_q <= held_d;
			rep_q  <= rep_d;
		end
	end

endmodule

FILE: sv/jeu_fifo.sv
// small entry queue between front end and byte encoder
module jeu_fifo #(
	parameter int Depth = jeu_pkg::QueueDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jeu_pkg::jeu_entry_t push_entry,
	input  logic                pop,
	output jeu_pkg::jeu_entry_t head,
	output jeu_pkg::jeu_qstat_t q_stat
);
	import jeu_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	jeu_entry_t      entries_q [Depth];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign q_stat.full  = (cnt_q == CW'(Depth));
	assign q_stat.valid = (cnt_q != '0);
	assign head         = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

`include "json_escape_to_utf8_macros.svh"

	`JEU_ASSERT_NEVER(a_push_full, clk, arst_n, push && q_stat.full)
	`JEU_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !q_stat.valid)

endmodule

FILE: sv/jeu_back.sv
// back end: utf-8 byte encoder, per-transaction byte limit and output register
module jeu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  jeu_pkg::jeu_qstat_t q_stat,
	input  jeu_pkg::jeu_entry_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last
);
	import jeu_pkg::*;

	localparam logic [2:0] MAX_BYTES_M1 = 3'd6;

	function automatic logic [1:0] utf8_lenm1(input logic [20:0] cp);
		logic [1:0] r;
		if (cp < 21'h80) begin
			r = 2'd0;
		end else if (cp < 21'h800) begin
			r = 2'd1;
		end else if (cp < 21'h10000) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] lenm1,
			input logic [1:0] idx);
		logic [1:0] sh;
		logic [7:0] r;
		sh = lenm1 - idx;
		r  = '0;
		if (idx == 2'd0) begin
			unique case (lenm1)
				2'd0: r = cp[7:0];
				2'd1: r = {3'b110, cp[10:6]};
				2'd2: r = {4'b1110, cp[15:12]};
				2'd3: r = {5'b11110, cp[20:18]};
				default: r = '0;
			endcase
		end else begin
			unique case (sh)
				2'd0: r = {2'b10, cp[5:0]};
				2'd1: r = {2'b10, cp[11:6]};
				2'd2: r = {2'b10, cp[17:12]};
				default: r = {2'b10, 6'd0};
			endcase
		end
		return r;
	endfunction

	jeu_entry_t  cur_q;
	logic        cur_valid_q;
	logic        slot_q;
	logic [1:0]  idx_q;
	logic [2:0]  cnt_q;
	logic        drop_q;
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        olast_q;

	logic        out_free;
	logic [1:0]  main_lenm1;
	logic [20:0] hi_cp;
	logic [20:0] cur_cp;
	logic [1:0]  cur_lenm1;
	logic [7:0]  cur_byte;
	logic        slot_end;
	logic        fin;
	logic        is_empty;
	logic        head_end;
	logic        consume;
	logic        emit;
	logic        item_done;
	logic        rl;
	logic        pop_look;
	logic        load;

	assign out_free   = !ovalid_q || out_ready;
	assign main_lenm1 = (cur_q.kind == KIND_RAW) ? 2'd0 : utf8_lenm1(cur_q.val);
	assign hi_cp      = {5'd0, 16'hD800 | {6'd0, cur_q.hi}};
	assign cur_cp     = slot_q ? cur_q.val : hi_cp;
	assign cur_lenm1  = slot_q ? main_lenm1 : 2'd2;
	assign cur_byte   = (slot_q && cur_q.kind == KIND_RAW) ? cur_q.val[7:0]
		: utf8_byte(cur_cp, cur_lenm1, idx_q);
	assign slot_end   = (idx_q == cur_lenm1);
	assign fin        = slot_end && (slot_q || cur_q.kind == KIND_NONE);
	assign is_empty   = !cur_q.hi_en && (cur_q.kind == KIND_NONE);
	assign head_end   = q_stat.valid && !head.hi_en && (head.kind == KIND_NONE);

	always_comb begin
		consume   = 1'b0;
		emit      = 1'b0;
		item_done = 1'b0;
		rl        = 1'b0;
		pop_look  = 1'b0;
		if (cur_valid_q) begin
			if (drop_q || is_empty) begin
				consume = 1'b1;
			end else if (out_free && !(fin && !cur_q.last && !q_stat.valid)) begin
				emit      = 1'b1;
				item_done = fin && (cur_q.last || head_end);
				rl        = item_done || (cnt_q == MAX_BYTES_M1);
				consume   = fin;
				pop_look  = fin && !cur_q.last && head_end;
			end
		end
	end

	assign load = q_stat.valid && !pop_look && (!cur_valid_q || consume);
	assign pop  = load || pop_look;

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q <= cur_byte;
			olast_q <= rl;
		end
		if (load) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q    <= 1'b0;
			cur_valid_q <= 1'b0;
			slot_q      <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
		end else begin
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			if (cur_valid_q && (drop_q || is_empty)) begin
				if (cur_q.last) begin
					drop_q <= 1'b0;
					cnt_q  <= '0;
				end
			end else if (emit) begin
				if (item_done) begin
					cnt_q <= '0;
				end else if (cnt_q == MAX_BYTES_M1) begin
					drop_q <= 1'b1;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
			if (load) begin
				cur_valid_q <= 1'b1;
				slot_q      <= !head.hi_en;
				idx_q       <= '0;
			end else if (consume) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				if (slot_end) begin
					slot_q <= 1'b1;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	assign out_valid = ovalid_q;
	assign out_byte  = obyte_q;
	assign out_last  = olast_q;

`include "json_escape_to_utf8_macros.svh"

	`JEU_ASSERT_NEVER(a_no_emit_drop, clk, arst_n, drop_q && emit)
	`JEU_ASSERT_IMPLY(a_cap_last, clk, arst_n, emit && (cnt_q == MAX_BYTES_M1), rl)

endmodule

FILE: dv/tb_json_escape_to_utf8.sv
// testbench of json_escape_to_utf8: escaped string characters in, predicted utf-8 bytes checked out
`timescale 1ns / 1ps

module tb_json_escape_to_utf8;

	typedef enum logic [1:0] {
		MODE_PLAIN,
		MODE_BSLASH,
		MODE_HEX
	} dec_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam int MAX_BYTES    = 7;
	localparam int RANDOM_ITEMS = 370;
	localparam int MAX_REPORTS  = 10;
	localparam int TAIL_CYCLES  = 40;

	localparam logic [7:0] ESC_CHARS [8] = '{"n", "t", "r", "\"", "\\", "/", "b", "f"};
	localparam logic [15:0] EDGE_CP [10] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
		16'h0800, 16'hFFFF, 16'hD800, 16'hDBFF, 16'hDC00, 16'hDFFF};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_in
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] byte_out
	logic       m_axis_tlast;

	json_escape_to_utf8 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder state of the predictor
	dec_mode_t   mode_r = MODE_PLAIN;
	logic [15:0] hexv = '0;
	logic [2:0]  hexn = '0;
	logic        hex_halt = 1'b0;
	logic [7:0]  held [3] = '{8'h00, 8'h00, 8'h00};
	logic [9:0]  hi_pend = '0;
	logic        hi_pend_v = 1'b0;

	logic [7:0] step_bytes [$];
	out_byte_t  utf8_expect [$];
	logic [7:0] text_q [$];

	int  errors = 0;
	int  sent_items = 0;
	bit  no_idle = 1'b0;
	int  stall_left = 0;

	function automatic void put_byte(input logic [7:0] b);
		if (step_bytes.size() < MAX_BYTES)
			step_bytes.push_back(b);
	endfunction

	function automatic void put_cp(input logic [20:0] cp);
		if (cp < 21'h80) begin
			put_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			put_byte(8'hC0 | cp[10:6]);
			put_byte(8'h80 | cp[5:0]);
		end else if (cp < 21'h10000) begin
			put_byte(8'hE0 | cp[15:12]);
			put_byte(8'h80 | cp[11:6]);
			put_byte(8'h80 | cp[5:0]);
		end else begin
			put_byte(8'hF0 | cp[20:18]);
			put_byte(8'h80 | cp[17:12]);
			put_byte(8'h80 | cp[11:6]);
			put_byte(8'h80 | cp[5:0]);
		end
	endfunction

	function automatic void flush_high();
		put_cp(21'hD800 + hi_pend);
		hi_pend_v = 1'b0;
	endfunction

	function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] d);
		d = '0;
		if (c >= "0" && c <= "9") begin
			d = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			d = 4'(c - "a" + 10);
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			d = 4'(c - "A" + 10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void resolve_cp(input logic [15:0] v);
		logic [20:0] cp;
		if (hi_pend_v) begin
			if (v >= 16'hDC00 && v <= 16'hDFFF) begin
				cp = ({11'd0, hi_pend} << 10) + {5'd0, v - 16'hDC00} + 21'h10000;
				put_cp(cp);
				hi_pend_v = 1'b0;
				return;
			end
			flush_high();
		end
		if (v >= 16'hD800 && v <= 16'hDBFF) begin
			hi_pend = 10'(v - 16'hD800);
			hi_pend_v = 1'b1;
		end else begin
			put_cp({5'd0, v});
		end
	endfunction

	function automatic void feed_char(input logic [7:0] c);
		logic [3:0] d;
		case (mode_r)
			MODE_BSLASH: begin
				mode_r = MODE_PLAIN;
				if (c == CH_U) begin
					mode_r = MODE_HEX;
					hexv = '0;
					hexn = '0;
					hex_halt = 1'b0;
					return;
				end
				if (hi_pend_v)
					flush_high();
				if (c == CH_N)
					put_byte(CH_LF);
				else if (c == CH_T)
					put_byte(CH_TAB);
				else if (c == CH_R)
					put_byte(CH_CR);
				else
					put_byte(c);
			end
			MODE_HEX: begin
				if (hexn < 3)
					held[hexn[1:0]] = c;
				if (!hex_halt && hex_nibble(c, d))
					hexv = {hexv[11:0], d};
				else
					hex_halt = 1'b1;
				hexn = hexn + 3'd1;
				if (hexn >= 4) begin
					mode_r = MODE_PLAIN;
					hexn = '0;
					resolve_cp(hexv);
				end
			end
			default: begin
				if (c == CH_BSLASH) begin
					mode_r = MODE_BSLASH;
					return;
				end
				if (hi_pend_v)
					flush_high();
				put_byte(c);
			end
		endcase
	endfunction

	// string end: an open \u gives 'u' and feeds its held characters through the decoder again
	function automatic void close_string();
		logic [7:0] replay [3];
		int n;
		while (mode_r != MODE_PLAIN) begin
			if (mode_r == MODE_BSLASH) begin
				mode_r = MODE_PLAIN;
			end else begin
				n = (hexn < 3) ? int'(hexn) : 3;
				replay = held;
				if (hi_pend_v)
					flush_high();
				put_byte(CH_U);
				mode_r = MODE_PLAIN;
				hexn = '0;
				for (int k = 0; k < n; k++)
					feed_char(replay[2'(k)]);
			end
		end
		if (hi_pend_v)
			flush_high();
		mode_r = MODE_PLAIN;
		hexv = '0;
		hexn = '0;
		hex_halt = 1'b0;
		hi_pend = '0;
		hi_pend_v = 1'b0;
	endfunction

	function automatic void decode_char(input logic [7:0] c, input logic is_end);
		out_byte_t e;
		step_bytes.delete();
		feed_char(c);
		if (is_end)
			close_string();
		foreach (step_bytes[i]) begin
			e.data = step_bytes[i];
			e.last = (i == step_bytes.size() - 1);
			utf8_expect.push_back(e);
		end
	endfunction

	// predict on accepted input first, then check the output transaction
	always @(posedge clk) begin
		out_byte_t e;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				decode_char(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (utf8_expect.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected byte %02h last %0b", m_axis_tdata, m_axis_tlast);
				end else begin
					e = utf8_expect.pop_front();
					if (m_axis_tdata !== e.data || m_axis_tlast !== e.last) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
								e.data, e.last, m_axis_tdata, m_axis_tlast);
					end
				end
			end
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 93)
			return $urandom_range(3, 6);
		return $urandom_range(15, 40);
	endfunction

	always @(posedge clk) begin
		if (no_idle) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= idle_len() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic push_char(input logic [7:0] c, input logic is_last);
		int gap;
		gap = (no_idle || $urandom_range(0, 99) < 60) ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= is_last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_items++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			push_char(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic wait_all_out();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (utf8_expect.size() != 0)
			@(posedge clk);
	endtask

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] base;
		base = $urandom_range(0, 1) ? "A" : "a";
		if (n < 10)
			return 8'("0" + n);
		return 8'(base + n - 10);
	endfunction

	function automatic void add_uesc(input logic [15:0] v);
		text_q.push_back(CH_BSLASH);
		text_q.push_back(CH_U);
		for (int i = 3; i >= 0; i--)
			text_q.push_back(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic void add_token();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			c = 8'($urandom_range(0, 255));
			if (c == CH_BSLASH)
				text_q.push_back(CH_BSLASH);
			text_q.push_back(c);
		end else if (r < 45) begin
			text_q.push_back(CH_BSLASH);
			c = ESC_CHARS[3'($urandom_range(0, 7))];
			if ($urandom_range(0, 3) == 0)
				c = 8'($urandom_range(0, 255));
			text_q.push_back(c == CH_U ? CH_N : c);
		end else if (r < 80) begin
			case ($urandom_range(0, 6))
				0: add_uesc(16'($urandom_range(16'h0000, 16'h007F)));
				1: add_uesc(16'($urandom_range(16'h0080, 16'h07FF)));
				2: add_uesc(16'($urandom_range(16'h0800, 16'hFFFF)));
				3: add_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
				4: add_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)));
				5: begin
					add_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
					add_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)));
				end
				default: add_uesc(EDGE_CP[4'($urandom_range(0, 9))]);
			endcase
		end else if (r < 92) begin
			// \u with non-hex characters scattered among the digits
			text_q.push_back(CH_BSLASH);
			text_q.push_back(CH_U);
			for (int i = 0; i < 4; i++) begin
				if ($urandom_range(0, 2) == 0)
					text_q.push_back(8'($urandom_range(0, 255)));
				else
					text_q.push_back(hex_char(4'($urandom_range(0, 15))));
			end
		end else begin
			text_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic test_plain_bytes();
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		send_text();
	endtask

	task automatic test_simple_escapes();
		// ends on a lone backslash
		add_str("\\n\\t\\r\\");
		send_text();
	endtask

	task automatic test_surrogates();
		add_str("\\uDFFF\\uD800\\uDFFF");
		send_text();
	endtask

	task automatic test_open_escape_at_end();
		add_str("\\uDBFF\\u-");
		send_text();
	endtask

	task automatic test_random_strings();
		int first;
		int n_tok;
		int cut;
		first = sent_items;
		while (sent_items - first < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 7) == 0);
			n_tok = $urandom_range(1, 8);
			repeat (n_tok) add_token();
			if ($urandom_range(0, 4) == 0) begin
				cut = $urandom_range(1, text_q.size());
				while (text_q.size() > cut)
					void'(text_q.pop_back());
			end
			send_text();
			if ($urandom_range(0, 9) == 0)
				wait_all_out();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_bytes();
		test_simple_escapes();
		test_surrogates();
		wait_all_out();
		test_open_escape_at_end();
		test_random_strings();
		wait_all_out();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && utf8_expect.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
